[rtl/hbt_pkg.sv]
// Shared constants for the hyperboloid boost transform core.
`timescale 1ns / 1ps
`default_nettype none
package hbt_pkg;
   localparam int FRAC_BITS_DEF = 20;
   localparam int WORD_BITS_DEF = 32;

   // request kind carried on req_tuser
   typedef enum logic {
      CMD_FWD = 1'b0,   // move point into the reference frame
      CMD_INV = 1'b1    // inverse transform back
   } cmd_type;
endpackage
`default_nettype wire

[rtl/hbt_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage, several lanes in lockstep.
`timescale 1ns / 1ps
`default_nettype none
module hbt_sqrt_pipe #(
   parameter int W     = 32,
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en_i,
   input  wire logic                   vld_i,
   input  wire logic [LANES*2*W-1:0]   rad_i,
   input  wire logic [PW-1:0]          pay_i,
   output logic                        vld_o,
   output logic [LANES*W-1:0]          root_o,
   output logic [PW-1:0]               pay_o
);
   logic          vld_ff  [0:W-1];
   logic [PW-1:0] pay_ff  [0:W-1];
   logic [2*W:0]  rem_ff  [0:W-1][0:LANES-1];
   logic [W-1:0]  root_ff [0:W-1][0:LANES-1];

   for (genvar k = 0; k < W; k++) begin : g_stage
      localparam int I = W - 1 - k;
      logic          vld_cur;
      logic [PW-1:0] pay_cur;

      if (k == 0) begin : g_first
         assign vld_cur = vld_i;
         assign pay_cur = pay_i;
      end else begin : g_next
         assign vld_cur = vld_ff[k-1];
         assign pay_cur = pay_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en_i) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en_i) begin
            pay_ff[k] <= pay_cur;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [2*W:0] rem_cur;
         logic [W-1:0] root_cur;
         logic [2*W:0] term;
         logic         fit;

         if (k == 0) begin : g_first
            assign rem_cur  = {1'b0, rad_i[l*2*W +: 2*W]};
            assign root_cur = '0;
         end else begin : g_next
            assign rem_cur  = rem_ff[k-1][l];
            assign root_cur = root_ff[k-1][l];
         end

         // (r + 2^I)^2 - r^2 = r*2^(I+1) + 2^(2I)
         assign term = ({{(W+1){1'b0}}, root_cur} << (I + 1))
                     + ((2*W+1)'(1) << (2 * I));
         assign fit  = rem_cur >= term;

         always_ff @(posedge clock) begin
            if (en_i) begin
               rem_ff[k][l]  <= fit ? rem_cur - term : rem_cur;
               root_ff[k][l] <= fit ? (root_cur | (W'(1) << I)) : root_cur;
            end
         end

         assign root_o[l*W +: W] = root_ff[W-1][l];
      end
   end

   assign vld_o = vld_ff[W-1];
   assign pay_o = pay_ff[W-1];
endmodule
`default_nettype wire

[rtl/hbt_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
`timescale 1ns / 1ps
`default_nettype none
module hbt_div_pipe #(
   parameter int W     = 32,
   parameter int LANES = 3,
   parameter int PW    = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en_i,
   input  wire logic                     vld_i,
   input  wire logic [LANES*2*W-1:0]     num_i,
   input  wire logic [W:0]               den_i,
   input  wire logic [PW-1:0]            pay_i,
   output logic                          vld_o,
   output logic [LANES*(W-1)-1:0]        quot_o,
   output logic [PW-1:0]                 pay_o
);
   localparam int QW = W - 1;

   logic          vld_ff  [0:QW-1];
   logic [PW-1:0] pay_ff  [0:QW-1];
   logic [W:0]    den_ff  [0:QW-1];
   logic [2*W-1:0] rem_ff [0:QW-1][0:LANES-1];
   logic [QW-1:0] quot_ff [0:QW-1][0:LANES-1];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int I = QW - 1 - k;
      logic          vld_cur;
      logic [PW-1:0] pay_cur;
      logic [W:0]    den_cur;
      logic [2*W-1:0] dsh;

      if (k == 0) begin : g_first
         assign vld_cur = vld_i;
         assign pay_cur = pay_i;
         assign den_cur = den_i;
      end else begin : g_next
         assign vld_cur = vld_ff[k-1];
         assign pay_cur = pay_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      assign dsh = {{(W-1){1'b0}}, den_cur} << I;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en_i) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en_i) begin
            pay_ff[k] <= pay_cur;
            den_ff[k] <= den_cur;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [2*W-1:0] rem_cur;
         logic [QW-1:0]  quot_cur;
         logic           fit;

         if (k == 0) begin : g_first
            assign rem_cur  = num_i[l*2*W +: 2*W];
            assign quot_cur = '0;
         end else begin : g_next
            assign rem_cur  = rem_ff[k-1][l];
            assign quot_cur = quot_ff[k-1][l];
         end

         assign fit = rem_cur >= dsh;

         always_ff @(posedge clock) begin
            if (en_i) begin
               rem_ff[k][l]  <= fit ? rem_cur - dsh : rem_cur;
               quot_ff[k][l] <= fit ? (quot_cur | (QW'(1) << I)) : quot_cur;
            end
         end

         assign quot_o[l*QW +: QW] = quot_ff[QW-1][l];
      end
   end

   assign vld_o = vld_ff[QW-1];
   assign pay_o = pay_ff[QW-1];
endmodule
`default_nettype wire

[rtl/hbt_rsp_buf.sv]
// Two-entry response buffer that decouples the pipeline from the response channel.
`timescale 1ns / 1ps
`default_nettype none
module hbt_rsp_buf #(
   parameter int DW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_i,
   input  wire logic [DW-1:0] data_i,
   output logic               full_o,
   output logic               tvalid_o,
   input  wire logic          tready_i,
   output logic [DW-1:0]      tdata_o
);
   logic [DW-1:0] mem_ff [0:1];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    cnt_ff;
   logic [1:0]    cnt_in;
   logic          pop;

   assign pop      = tvalid_o && tready_i;
   assign tvalid_o = cnt_ff != 2'd0;
   assign full_o   = cnt_ff == 2'd2;
   assign tdata_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push_i && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push_i) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push_i) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end
endmodule
`default_nettype wire

[rtl/hyperboloid_boost_transform_core.sv]
// Top level of the hyperboloid Lorentz boost transform pipeline.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: point_x,point_y,ref_x,ref_y
//          |     |                       | tuser: cmd
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: out_x,out_y,out_z; tuser: saturated
//
// One request per clock while the response buffer has room, one response per request, in order.
// The path from request accept to response runs through two square-root pipes of
// WORD_BITS stages, one divider pipe of WORD_BITS-1 stages, nine capture, product
// and sum stages and the response buffer.
// Synchronous reset clears the valid bits and the response buffer only.
// The whole pipeline advances while the two-entry response buffer has room;
// req_tready is that registered room flag, so stalls lose and repeat nothing.
`timescale 1ns / 1ps
`default_nettype none
module hyperboloid_boost_transform_core #(
   parameter int FRAC_BITS = hbt_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = hbt_pkg::WORD_BITS_DEF,
   localparam int REQ_DW   = ((4 * WORD_BITS + 7) / 8) * 8,
   localparam int RSP_DW   = ((3 * WORD_BITS - 1 + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_DW-1:0] req_tdata,  // point_x, point_y, ref_x, ref_y (low to high)
   input  wire logic              req_tuser,  // cmd
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_DW-1:0]      rsp_tdata,  // out_x, out_y, out_z, zero fill (low to high)
   output logic                   rsp_tuser   // saturated
);
   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int ACC = 2 * W + 4;
   localparam int RDW = 3 * W - 1;
   localparam logic [2*W-1:0] ONE_SQ  = (2*W)'(1) << (2 * F);
   localparam logic [W:0]     ONE_W1  = (W+1)'(1) << F;

   logic en;     // pipeline advance
   logic full;

   assign en         = !full;
   assign req_tready = en;

   // ---- stage 1: request capture
   logic         s1_vld_ff;
   logic         s1_cmd_ff;
   logic [W-1:0] s1_px_ff, s1_py_ff, s1_rx_ff, s1_ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff <= req_tuser;
         s1_px_ff  <= req_tdata[0*W +: W];
         s1_py_ff  <= req_tdata[1*W +: W];
         s1_rx_ff  <= req_tdata[2*W +: W];
         s1_ry_ff  <= req_tdata[3*W +: W];
      end
   end

   // ---- stage 2: squares of magnitudes
   logic [W-1:0]   m_px, m_py, m_rx, m_ry;
   logic           s2_vld_ff;
   logic           s2_cmd_ff;
   logic [W-1:0]   s2_px_ff, s2_py_ff, s2_rx_ff, s2_ry_ff;
   logic [2*W-1:0] s2_px2_ff, s2_py2_ff, s2_rx2_ff, s2_ry2_ff;

   assign m_px = s1_px_ff[W-1] ? W'(-s1_px_ff) : s1_px_ff;
   assign m_py = s1_py_ff[W-1] ? W'(-s1_py_ff) : s1_py_ff;
   assign m_rx = s1_rx_ff[W-1] ? W'(-s1_rx_ff) : s1_rx_ff;
   assign m_ry = s1_ry_ff[W-1] ? W'(-s1_ry_ff) : s1_ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_rx_ff  <= s1_rx_ff;
         s2_ry_ff  <= s1_ry_ff;
         s2_px2_ff <= (2*W)'(m_px) * (2*W)'(m_px);
         s2_py2_ff <= (2*W)'(m_py) * (2*W)'(m_py);
         s2_rx2_ff <= (2*W)'(m_rx) * (2*W)'(m_rx);
         s2_ry2_ff <= (2*W)'(m_ry) * (2*W)'(m_ry);
      end
   end

   // ---- stage 3: radicands x^2 + y^2 + 1 (sum fits below 2^(2W))
   logic           s3_vld_ff;
   logic [4*W:0]   s3_pay_ff;   // cmd, px, py, rx, ry
   logic [2*W-1:0] s3_radp_ff, s3_radr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pay_ff  <= {s2_cmd_ff, s2_px_ff, s2_py_ff, s2_rx_ff, s2_ry_ff};
         s3_radp_ff <= s2_px2_ff + s2_py2_ff + ONE_SQ;
         s3_radr_ff <= s2_rx2_ff + s2_ry2_ff + ONE_SQ;
      end
   end

   // ---- square roots: pz (lane 0) and zr (lane 1)
   logic           q1_vld;
   logic [2*W-1:0] q1_root;
   logic [4*W:0]   q1_pay;

   hbt_sqrt_pipe #(.W(W), .LANES(2), .PW(4*W+1)) u_sqrt_in (
      .clock  (clock),
      .reset  (reset),
      .en_i   (en),
      .vld_i  (s3_vld_ff),
      .rad_i  ({s3_radr_ff, s3_radp_ff}),
      .pay_i  (s3_pay_ff),
      .vld_o  (q1_vld),
      .root_o (q1_root),
      .pay_o  (q1_pay)
   );

   // ---- stage 4: divisor zr + 1 and numerators rx^2, ry^2, |rx*ry|
   logic [W-1:0]   q1_rx, q1_ry, m4_rx, m4_ry;
   logic           s4_vld_ff;
   logic [5*W:0]   s4_pay_ff;   // cmd, px, py, pz, rx, ry
   logic [W:0]     s4_den_ff;
   logic [2*W-1:0] s4_nxx_ff, s4_nyy_ff, s4_nxy_ff;

   assign q1_rx = q1_pay[W +: W];
   assign q1_ry = q1_pay[0 +: W];
   assign m4_rx = q1_rx[W-1] ? W'(-q1_rx) : q1_rx;
   assign m4_ry = q1_ry[W-1] ? W'(-q1_ry) : q1_ry;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= q1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_pay_ff <= {q1_pay[4*W:2*W], q1_root[0 +: W], q1_pay[2*W-1:0]};
         s4_den_ff <= {1'b0, q1_root[W +: W]} + ONE_W1;
         s4_nxx_ff <= (2*W)'(m4_rx) * (2*W)'(m4_rx);
         s4_nyy_ff <= (2*W)'(m4_ry) * (2*W)'(m4_ry);
         s4_nxy_ff <= (2*W)'(m4_rx) * (2*W)'(m4_ry);
      end
   end

   // ---- divider: axx (lane 0), ayy (lane 1), |axy| (lane 2)
   logic             dv_vld;
   logic [3*W-4:0]   dv_quot;
   logic [5*W:0]     dv_pay;

   hbt_div_pipe #(.W(W), .LANES(3), .PW(5*W+1)) u_div (
      .clock  (clock),
      .reset  (reset),
      .en_i   (en),
      .vld_i  (s4_vld_ff),
      .num_i  ({s4_nxy_ff, s4_nyy_ff, s4_nxx_ff}),
      .den_i  (s4_den_ff),
      .pay_i  (s4_pay_ff),
      .vld_o  (dv_vld),
      .quot_o (dv_quot),
      .pay_o  (dv_pay)
   );

   // ---- stage 5: matrix coefficients
   logic                dv_cmd;
   logic [W-1:0]        dv_px, dv_py, dv_pz, dv_rx, dv_ry;
   logic [W-2:0]        q_xx, q_yy, q_xy;
   logic                s5_vld_ff;
   logic signed [W:0]   s5_mxx_ff, s5_myy_ff, s5_mxy_ff, s5_cx_ff, s5_cy_ff;
   logic signed [W:0]   s5_px_ff, s5_py_ff, s5_pz_ff;

   assign dv_cmd = dv_pay[5*W];
   assign dv_px  = dv_pay[4*W +: W];
   assign dv_py  = dv_pay[3*W +: W];
   assign dv_pz  = dv_pay[2*W +: W];
   assign dv_rx  = dv_pay[1*W +: W];
   assign dv_ry  = dv_pay[0*W +: W];
   assign q_xx   = dv_quot[0*(W-1) +: W-1];
   assign q_yy   = dv_quot[1*(W-1) +: W-1];
   assign q_xy   = dv_quot[2*(W-1) +: W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_mxx_ff <= $signed({2'b00, q_xx} + ONE_W1);
         s5_myy_ff <= $signed({2'b00, q_yy} + ONE_W1);
         // off-diagonal truncates toward zero, sign from rx*ry
         s5_mxy_ff <= (dv_rx[W-1] ^ dv_ry[W-1]) ? $signed(-{2'b00, q_xy})
                                                : $signed({2'b00, q_xy});
         // third column: -r moves into the frame, +r moves back
         s5_cx_ff  <= (dv_cmd == hbt_pkg::CMD_INV) ? $signed({dv_rx[W-1], dv_rx})
                                                   : -$signed({dv_rx[W-1], dv_rx});
         s5_cy_ff  <= (dv_cmd == hbt_pkg::CMD_INV) ? $signed({dv_ry[W-1], dv_ry})
                                                   : -$signed({dv_ry[W-1], dv_ry});
         s5_px_ff  <= $signed({dv_px[W-1], dv_px});
         s5_py_ff  <= $signed({dv_py[W-1], dv_py});
         s5_pz_ff  <= $signed({1'b0, dv_pz});
      end
   end

   // ---- stage 6: row products
   logic                   s6_vld_ff;
   logic signed [2*W+1:0]  s6_x0_ff, s6_x1_ff, s6_x2_ff, s6_y0_ff, s6_y1_ff, s6_y2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_x0_ff <= s5_mxx_ff * s5_px_ff;
         s6_x1_ff <= s5_mxy_ff * s5_py_ff;
         s6_x2_ff <= s5_cx_ff  * s5_pz_ff;
         s6_y0_ff <= s5_mxy_ff * s5_px_ff;
         s6_y1_ff <= s5_myy_ff * s5_py_ff;
         s6_y2_ff <= s5_cy_ff  * s5_pz_ff;
      end
   end

   // ---- stage 7: sum, arithmetic shift, saturate x and y
   logic signed [ACC-1:0] acc_x, acc_y, sh_x, sh_y;
   logic                  ovf_x, ovf_y;
   logic [W-1:0]          ox_in, oy_in;
   logic                  s7_vld_ff;
   logic                  s7_sat_ff;
   logic [W-1:0]          s7_ox_ff, s7_oy_ff;

   assign acc_x = ACC'(s6_x0_ff) + ACC'(s6_x1_ff) + ACC'(s6_x2_ff);
   assign acc_y = ACC'(s6_y0_ff) + ACC'(s6_y1_ff) + ACC'(s6_y2_ff);
   assign sh_x  = acc_x >>> F;
   assign sh_y  = acc_y >>> F;
   assign ovf_x = !((&sh_x[ACC-1:W-1]) || !(|sh_x[ACC-1:W-1]));
   assign ovf_y = !((&sh_y[ACC-1:W-1]) || !(|sh_y[ACC-1:W-1]));
   assign ox_in = ovf_x ? {sh_x[ACC-1], {(W-1){!sh_x[ACC-1]}}} : sh_x[W-1:0];
   assign oy_in = ovf_y ? {sh_y[ACC-1], {(W-1){!sh_y[ACC-1]}}} : sh_y[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_ox_ff  <= ox_in;
         s7_oy_ff  <= oy_in;
         s7_sat_ff <= ovf_x || ovf_y;
      end
   end

   // ---- stage 8: squares of the new x and y
   logic [W-1:0]   m_ox, m_oy;
   logic           s8_vld_ff;
   logic [2*W:0]   s8_pay_ff;   // sat, ox, oy
   logic [2*W-1:0] s8_ox2_ff, s8_oy2_ff;

   assign m_ox = s7_ox_ff[W-1] ? W'(-s7_ox_ff) : s7_ox_ff;
   assign m_oy = s7_oy_ff[W-1] ? W'(-s7_oy_ff) : s7_oy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_pay_ff <= {s7_sat_ff, s7_ox_ff, s7_oy_ff};
         s8_ox2_ff <= (2*W)'(m_ox) * (2*W)'(m_ox);
         s8_oy2_ff <= (2*W)'(m_oy) * (2*W)'(m_oy);
      end
   end

   // ---- stage 9: radicand for the new z
   logic           s9_vld_ff;
   logic [2*W:0]   s9_pay_ff;
   logic [2*W-1:0] s9_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (en) begin
         s9_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_pay_ff <= s8_pay_ff;
         s9_rad_ff <= s8_ox2_ff + s8_oy2_ff + ONE_SQ;
      end
   end

   logic         q2_vld;
   logic [W-1:0] q2_root;
   logic [2*W:0] q2_pay;

   hbt_sqrt_pipe #(.W(W), .LANES(1), .PW(2*W+1)) u_sqrt_out (
      .clock  (clock),
      .reset  (reset),
      .en_i   (en),
      .vld_i  (s9_vld_ff),
      .rad_i  (s9_rad_ff),
      .pay_i  (s9_pay_ff),
      .vld_o  (q2_vld),
      .root_o (q2_root),
      .pay_o  (q2_pay)
   );

   // ---- z clip and hand-off to the response buffer
   logic [W-2:0]  oz;
   logic          sat_all;
   logic [RDW:0]  rsp_word;   // saturated, out_z, out_y, out_x from high to low
   logic [RDW:0]  buf_word;

   assign oz       = q2_root[W-1] ? {(W-1){1'b1}} : q2_root[W-2:0];
   assign sat_all  = q2_pay[2*W] || q2_root[W-1];
   assign rsp_word = {sat_all, oz, q2_pay[0 +: W], q2_pay[W +: W]};

   hbt_rsp_buf #(.DW(RDW + 1)) u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push_i   (q2_vld && en),
      .data_i   (rsp_word),
      .full_o   (full),
      .tvalid_o (rsp_tvalid),
      .tready_i (rsp_tready),
      .tdata_o  (buf_word)
   );

   assign rsp_tdata = {{(RSP_DW-RDW){1'b0}}, buf_word[RDW-1:0]};
   assign rsp_tuser = buf_word[RDW];
endmodule
`default_nettype wire

[test/tb_hyperboloid_boost_transform_core.sv]
// Self-checking testbench for the hyperboloid boost transform core.
`timescale 1ns / 1ps
`default_nettype none

// Expected responses and the fixed-point boost arithmetic behind them.
class boost_scoreboard;
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [30:0]        z;
      logic               sat;
   } boost_result_type;

   boost_result_type pending[$];
   int               errors = 0;

   // floor(sqrt(n)) for a 128-bit radicand
   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         t  = r | (64'd1 << i);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= n) r = t;
      end
      return r;
   endfunction

   // sqrt(x^2 + y^2 + 1) in Q.20
   function automatic logic [63:0] z_of(logic signed [127:0] x, logic signed [127:0] y);
      logic [127:0] s;
      s = x * x + y * y + (128'd1 << 40);
      return isqrt(s);
   endfunction

   function automatic logic signed [31:0] clip(logic signed [127:0] v, inout logic sat);
      if (v > 128'sh7FFF_FFFF) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -128'sh8000_0000) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Accepted request: predict its response.
   function void note_request(hbt_pkg::cmd_type cmd, logic signed [31:0] px_i,
                              logic signed [31:0] py_i, logic signed [31:0] rx_i,
                              logic signed [31:0] ry_i);
      logic signed [127:0] px, py, rx, ry, pz, d, axx, ayy, axy, cx, cy, one, acc, ox, oy;
      logic [63:0]         zz;
      boost_result_type    e;
      px  = px_i;
      py  = py_i;
      rx  = rx_i;
      ry  = ry_i;
      one = 128'sd1 << 20;
      pz  = $signed({64'd0, z_of(px, py)});
      d   = $signed({64'd0, z_of(rx, ry)}) + one;
      axx = (rx * rx) / d;
      ayy = (ry * ry) / d;
      axy = ((rx < 0 ? -rx : rx) * (ry < 0 ? -ry : ry)) / d;
      if ((rx < 0) != (ry < 0)) axy = -axy;
      cx  = (cmd == hbt_pkg::CMD_INV) ? rx : -rx;
      cy  = (cmd == hbt_pkg::CMD_INV) ? ry : -ry;
      e.sat = 1'b0;
      acc = (one + axx) * px + axy * py + cx * pz;
      e.x = clip(acc >>> 20, e.sat);
      acc = axy * px + (one + ayy) * py + cy * pz;
      e.y = clip(acc >>> 20, e.sat);
      ox = e.x;
      oy = e.y;
      zz = z_of(ox, oy);
      if (zz > 64'h7FFF_FFFF) begin
         zz = 64'h7FFF_FFFF;
         e.sat = 1'b1;
      end
      e.z = zz[30:0];
      pending.push_back(e);
   endfunction

   // Accepted response: compare with the oldest prediction.
   function void check_response(logic [95:0] data, logic user);
      boost_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response data=%h sat=%b", $time, data, user);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (data[31:0] !== e.x) begin
         $display("%0t: out_x expected %h actual %h", $time, e.x, data[31:0]);
         errors++;
      end
      if (data[63:32] !== e.y) begin
         $display("%0t: out_y expected %h actual %h", $time, e.y, data[63:32]);
         errors++;
      end
      if (data[94:64] !== e.z) begin
         $display("%0t: out_z expected %h actual %h", $time, e.z, data[94:64]);
         errors++;
      end
      if (user !== e.sat) begin
         $display("%0t: saturated expected %b actual %b", $time, e.sat, user);
         errors++;
      end
   endfunction
endclass

module tb_hyperboloid_boost_transform_core;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 150;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // point_x, point_y, ref_x, ref_y (low to high)
   logic         req_tuser = 1'b0; // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;        // out_x, out_y, out_z, zero fill (low to high)
   logic         rsp_tuser;        // saturated

   boost_scoreboard board = new();
   bit              calm  = 1'b0;  // no idling in the closing stretch
   int              cycles = 0;

   hyperboloid_boost_transform_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_hyperboloid_boost_transform_core: errors");
         $finish;
      end
   end

   // Response side: random stall bursts, check every accepted response.
   initial begin : rsp_side
      int stall;
      stall = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
         if (stall > 0) begin
            stall--;
            if (stall == 0) rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Drive one request; tvalid stays high, the caller drops it for a gap.
   task automatic send_request(hbt_pkg::cmd_type cmd, logic [31:0] px, logic [31:0] py,
                               logic [31:0] rx, logic [31:0] ry);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {ry, rx, py, px};
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, px, py, rx, ry);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Coordinate: mostly plausible magnitudes, sometimes any bit pattern.
   function automatic logic [31:0] coord();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2:    return $signed($urandom_range(0, 32'h7FFF)) - 32'sh4000;
         default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   initial begin : req_side
      logic [31:0] p, q;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: origin, extremes, reference equal to point, saturation
      send_request(hbt_pkg::CMD_FWD, 0, 0, 0, 0);
      send_request(hbt_pkg::CMD_INV, 0, 0, 0, 0);
      send_request(hbt_pkg::CMD_FWD, 32'h0010_0000, 0, 0, 0);
      send_request(hbt_pkg::CMD_INV, 0, 32'hFFF0_0000, 32'h0020_0000, 0);
      send_request(hbt_pkg::CMD_FWD, 32'h0030_0000, 32'hFFE0_0000,
                   32'h0030_0000, 32'hFFE0_0000);
      send_request(hbt_pkg::CMD_INV, 32'h0030_0000, 32'hFFE0_0000,
                   32'h0030_0000, 32'hFFE0_0000);
      send_request(hbt_pkg::CMD_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(hbt_pkg::CMD_INV, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
      send_request(hbt_pkg::CMD_FWD, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
      send_request(hbt_pkg::CMD_INV, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000);
      send_request(hbt_pkg::CMD_FWD, 32'h0100_0000, 0, 32'hFF00_0000, 0);
      send_request(hbt_pkg::CMD_INV, 32'h0100_0000, 0, 32'h0100_0000, 0);
      send_request(hbt_pkg::CMD_FWD, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0000_0001);
      send_request(hbt_pkg::CMD_INV, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0000_0001);
      send_request(hbt_pkg::CMD_FWD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(hbt_pkg::CMD_INV, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'hAAAA_AAAA, 32'h5555_5555);

      // random; the closing stretch runs at full rate on both sides
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 150) calm = 1'b1;
         maybe_gap();
         p = coord();
         q = coord();
         if ($urandom_range(0, 5) == 0)  // point equal to reference, random command
            send_request(hbt_pkg::cmd_type'($urandom_range(0, 1)), p, q, p, q);
         else
            send_request(hbt_pkg::cmd_type'($urandom_range(0, 1)), p, q, coord(), coord());
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("tb_hyperboloid_boost_transform_core: clean");
      else
         $display("tb_hyperboloid_boost_transform_core: errors");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
rtl/hbt_pkg.sv
rtl/hbt_sqrt_pipe.sv
rtl/hbt_div_pipe.sv
rtl/hbt_rsp_buf.sv
rtl/hyperboloid_boost_transform_core.sv
test/tb_hyperboloid_boost_transform_core.sv
